### hw/rtl/rc_cap_pkg.sv
// ----------------------------------------------------------------------------
// rc_cap_pkg
// Shared types and constants for the two-channel rc pulse capture block.
// ----------------------------------------------------------------------------
package rc_cap_pkg;

  localparam int unsigned TS_W      = 32;
  localparam int unsigned WIDTH_W   = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  // timeout in us: 65535 ms * 1000 still fits
  localparam int unsigned TMO_US_W  = 26;

  localparam logic [9:0] US_PER_MS = 10'd1000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

  localparam logic [CFG_W-1:0]    PULSE_MIN_RST  = 16'd1000;
  localparam logic [CFG_W-1:0]    PULSE_MAX_RST  = 16'd2000;
  localparam logic [TMO_US_W-1:0] TIMEOUT_US_RST = 26'd250000;

  // edge channel codes
  localparam logic CH_THROTTLE = 1'b0;
  localparam logic CH_STEERING = 1'b1;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef struct packed {
    logic [CFG_W-1:0]    pulse_min;
    logic [CFG_W-1:0]    pulse_max;
    logic [TMO_US_W-1:0] timeout_us;
  } cap_cfg_t;

  typedef struct packed {
    logic            adv;    // word moves from input to result register
    logic            edge_hit;
    logic            level;
    logic [TS_W-1:0] now_us;
  } chan_evt_t;

endpackage

### hw/rtl/rc_cap_chan.sv
// ----------------------------------------------------------------------------
// rc_cap_chan
// One capture channel: rise latch, accepted width and fall time, freshness.
// ----------------------------------------------------------------------------
module rc_cap_chan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rc_cap_pkg::cap_cfg_t          cfg,
  input  rc_cap_pkg::chan_evt_t         evt,
  output logic [rc_cap_pkg::WIDTH_W-1:0] width_nxt,
  output logic                          fresh_nxt
);
  import rc_cap_pkg::*;

  logic [TS_W-1:0]    rise_r,  rise_nxt;
  logic [TS_W-1:0]    fall_r,  fall_nxt;
  logic [WIDTH_W-1:0] width_r;
  logic [TS_W-1:0]    meas;
  logic [TS_W-1:0]    elapsed;
  logic               in_range;
  logic               take;
  logic               old_fresh;

  assign meas     = evt.now_us - rise_r;
  assign in_range = (meas >= {{(TS_W-CFG_W){1'b0}}, cfg.pulse_min}) &&
                    (meas <= {{(TS_W-CFG_W){1'b0}}, cfg.pulse_max});
  assign take     = evt.edge_hit && !evt.level && (rise_r != '0) && in_range;

  // freshness against the old fall time; a new pulse has zero elapsed
  assign elapsed   = evt.now_us - fall_r;
  assign old_fresh = (fall_r != '0) &&
                     (elapsed < {{(TS_W-TMO_US_W){1'b0}}, cfg.timeout_us});

  always_comb begin
    rise_nxt  = rise_r;
    fall_nxt  = fall_r;
    width_nxt = width_r;
    fresh_nxt = old_fresh;
    if (evt.edge_hit) begin
      if (evt.level) begin
        rise_nxt = evt.now_us;
      end else if (rise_r != '0) begin
        rise_nxt = '0;
      end
    end
    if (take) begin
      fall_nxt  = evt.now_us;
      width_nxt = meas[WIDTH_W-1:0];
      fresh_nxt = (evt.now_us != '0) && (cfg.timeout_us != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_r  <= '0;
      fall_r  <= '0;
      width_r <= '0;
    end else if (evt.adv) begin
      rise_r  <= rise_nxt;
      fall_r  <= fall_nxt;
      width_r <= width_nxt;
    end
  end

endmodule

### hw/rtl/rc_cap_cfg.sv
// ----------------------------------------------------------------------------
// rc_cap_cfg
// Configuration registers; the timeout is kept in microseconds.
// ----------------------------------------------------------------------------
module rc_cap_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rc_cap_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [rc_cap_pkg::CFG_W-1:0]     cfg_wdata,
  output rc_cap_pkg::cap_cfg_t            cfg
);
  import rc_cap_pkg::*;

  cap_cfg_t            cfg_r;
  logic [TMO_US_W-1:0] tmo_us;

  assign tmo_us = {{(TMO_US_W-CFG_W){1'b0}}, cfg_wdata} *
                  {{(TMO_US_W-10){1'b0}}, US_PER_MS};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_min  <= PULSE_MIN_RST;
      cfg_r.pulse_max  <= PULSE_MAX_RST;
      cfg_r.timeout_us <= TIMEOUT_US_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_PULSE_MIN: cfg_r.pulse_min  <= cfg_wdata;
        CFG_PULSE_MAX: cfg_r.pulse_max  <= cfg_wdata;
        CFG_TIMEOUT:   cfg_r.timeout_us <= tmo_us;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### hw/rtl/rc_pwm_pulse_capture_unit.sv
// ----------------------------------------------------------------------------
// rc_pwm_pulse_capture_unit
// Two-channel rc servo pulse capture (throttle, steering) with freshness.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per timer sample or pin edge. tuser = {channel, kind},
//           tdata = {pad, now_us, level}. kind 0 is a plain time sample.
//   out_* : exactly one word per input word, in order, reporting both stored
//           widths, a fresh flag per channel and the link flag.
//   cfg_* : single-cycle register writes (min width, max width, timeout in
//           ms); write only while no word is in flight.
// Timing: an accepted word enters the input register; its result is loaded
//   into the output register when that is free (empty or being taken), and
//   out_tvalid then stays high until the output word is taken.
// Throughput: one word per clock while out_tready is high; the channel state
//   is updated in the same cycle the word moves into the output register, so
//   back-to-back edges on one channel see each other.
// Reset: clears both channels (no rise, never seen, width zero), loads the
//   default limits and empties both registers.
// Stall: with out_tready low the output word holds; one more word waits in
//   the input register, then in_tready drops until the output is taken.
// ----------------------------------------------------------------------------
module rc_pwm_pulse_capture_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [0] level, [32:1] now_us, [39:33] zero
  input  logic [rc_cap_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] kind, [1] channel
  input  logic [rc_cap_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] throttle_width, [16] throttle_fresh, [32:17] steering_width,
  // [33] steering_fresh, [34] link_active, [39:35] zero
  output logic [rc_cap_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                              cfg_we,
  input  logic [rc_cap_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [rc_cap_pkg::CFG_W-1:0]       cfg_wdata
);
  import rc_cap_pkg::*;

  localparam int unsigned RES_W = 2 * WIDTH_W + 3;

  cap_cfg_t              cfg;
  logic                  iv_r;
  logic [IN_TDATA_W-1:0] idata_r;
  logic [IN_TUSER_W-1:0] iuser_r;
  logic                  ov_r;
  logic [OUT_TDATA_W-1:0] odata_r, odata_nxt;
  logic                  adv;
  logic                  kind, chan, level;
  logic [TS_W-1:0]       now_us;
  chan_evt_t             evt_thr, evt_str;
  logic [WIDTH_W-1:0]    thr_width, str_width;
  logic                  thr_fresh, str_fresh;

  rc_cap_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign adv       = iv_r && (!ov_r || out_tready);
  assign in_tready = !iv_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_tready) begin
      iv_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      idata_r <= in_tdata;
      iuser_r <= in_tuser;
    end
  end

  assign kind   = iuser_r[0];
  assign chan   = iuser_r[1];
  assign level  = idata_r[0];
  assign now_us = idata_r[TS_W:1];

  always_comb begin
    evt_thr.adv      = adv;
    evt_thr.edge_hit = kind && (chan == CH_THROTTLE);
    evt_thr.level    = level;
    evt_thr.now_us   = now_us;
    evt_str.adv      = adv;
    evt_str.edge_hit = kind && (chan == CH_STEERING);
    evt_str.level    = level;
    evt_str.now_us   = now_us;
  end

  rc_cap_chan u_thr (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .evt       (evt_thr),
    .width_nxt (thr_width),
    .fresh_nxt (thr_fresh)
  );

  rc_cap_chan u_str (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .evt       (evt_str),
    .width_nxt (str_width),
    .fresh_nxt (str_fresh)
  );

  assign odata_nxt = {{(OUT_TDATA_W-RES_W){1'b0}}, thr_fresh && str_fresh,
                      str_fresh, str_width, thr_fresh, thr_width};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (!ov_r || out_tready) begin
      ov_r <= iv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      odata_r <= odata_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = odata_r;

endmodule

### hw/rtl/rc_cap_checker.sv
// ----------------------------------------------------------------------------
// rc_cap_checker
// Port-level checks for the rc pulse capture block, bound to the top level.
// ----------------------------------------------------------------------------
module rc_cap_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [rc_cap_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import rc_cap_pkg::*;

  // link flag is the and of both fresh flags
  a_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[34] == (out_tdata[16] && out_tdata[33])))
    else $error("link_active does not match fresh flags");

  // reset empties the result register
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid right after reset");

  // input side only backs up when the result side is full and stalled
  a_bp: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result word changed");

endmodule

bind rc_pwm_pulse_capture_unit rc_cap_checker u_rc_cap_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
